@@ rtl/terminal_frame_diff_encoder_defines.svh @@
// Assertion macros for the terminal frame diff encoder
`ifndef TERMINAL_FRAME_DIFF_ENCODER_DEFINES_SVH
`define TERMINAL_FRAME_DIFF_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define TFDE_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tfde: check failed");
`define TFDE_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tfde: check failed");
`else
`define TFDE_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define TFDE_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

@@ rtl/tfde_pkg.sv @@
// Types, byte codes and digit helpers for the terminal frame diff encoder
`default_nettype none
package tfde_pkg;

  localparam int GLYPH_W = 32;
  localparam int LEN_W   = 3;
  localparam int COLOR_W = 9;
  localparam int CFG_W   = 8;
  localparam int BCD_W   = 12;
  localparam int SLOTS   = 36;
  localparam int MV_BASE = 0;
  localparam int FG_BASE = 10;
  localparam int BG_BASE = 21;
  localparam int GL_BASE = 32;

  localparam logic [0:0] REG_COLUMNS = 1'd0;
  localparam logic [0:0] REG_ROWS    = 1'd1;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_FG    = 8'h33;
  localparam logic [7:0] CH_BG    = 8'h34;
  localparam logic [3:0] CH_DIGIT_HI = 4'h3;

  localparam logic [LEN_W-1:0]   LEN_MAX       = 3'd4;
  localparam logic [COLOR_W-1:0] COLOR_DEFAULT = 9'h1FF;
  localparam logic [BCD_W-1:0]   BCD_ONE       = 12'h001;

  typedef struct packed {
    logic                 valid;
    logic [GLYPH_W-1:0]   bytes;
    logic [LEN_W-1:0]     len;
    logic [COLOR_W-1:0]   fg;
    logic [COLOR_W-1:0]   bg;
  } cell_t;

  typedef struct packed {
    logic [10:0][7:0] b;
    logic [10:0]      m;
  } color_seg_t;

  typedef struct packed {
    logic [9:0][7:0] b;
    logic [9:0]      m;
  } move_seg_t;

  function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
    logic [BCD_W-1:0] r;
    r = v;
    if (r[3:0] == 4'd9) begin
      r[3:0] = 4'd0;
      if (r[7:4] == 4'd9) begin
        r[7:4]  = 4'd0;
        r[11:8] = r[11:8] + 4'd1;
      end else begin
        r[7:4] = r[7:4] + 4'd1;
      end
    end else begin
      r[3:0] = r[3:0] + 4'd1;
    end
    return r;
  endfunction

  function automatic logic [BCD_W-1:0] color_bcd(input logic [7:0] v);
    logic [19:0] s;
    s = {12'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (s[11:8] >= 4'd5)  s[11:8]  = s[11:8] + 4'd3;
      if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
      if (s[19:16] >= 4'd5) s[19:16] = s[19:16] + 4'd3;
      s = s << 1;
    end
    return s[19:8];
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return {CH_DIGIT_HI, d};
  endfunction

  // decimal digit presence: leading zeros dropped, units always sent
  function automatic logic [2:0] digit_mask(input logic [BCD_W-1:0] v);
    return {v[11:8] != 4'd0, (v[11:8] != 4'd0) || (v[7:4] != 4'd0), 1'b1};
  endfunction

  function automatic color_seg_t color_seg(input logic [COLOR_W-1:0] c,
                                           input logic [7:0] base);
    color_seg_t       s;
    logic [BCD_W-1:0] d;
    logic [2:0]       dm;
    d  = color_bcd(c[7:0]);
    dm = digit_mask(d);
    s.b[0]  = CH_ESC;
    s.b[1]  = CH_LBR;
    s.b[2]  = base;
    s.b[3]  = c[8] ? CH_NINE : CH_EIGHT;
    s.b[4]  = CH_SEMI;
    s.b[5]  = CH_FIVE;
    s.b[6]  = CH_SEMI;
    s.b[7]  = digit_char(d[11:8]);
    s.b[8]  = digit_char(d[7:4]);
    s.b[9]  = digit_char(d[3:0]);
    s.b[10] = CH_M;
    if (c[8]) begin
      s.m = 11'b100_0000_1111;
    end else begin
      s.m = {1'b1, dm[0], dm[1], dm[2], 7'b111_1111};
    end
    return s;
  endfunction

  function automatic move_seg_t move_seg(input logic [BCD_W-1:0] r,
                                         input logic [BCD_W-1:0] c);
    move_seg_t  s;
    logic [2:0] rm;
    logic [2:0] cm;
    rm = digit_mask(r);
    cm = digit_mask(c);
    s.b[0] = CH_ESC;
    s.b[1] = CH_LBR;
    s.b[2] = digit_char(r[11:8]);
    s.b[3] = digit_char(r[7:4]);
    s.b[4] = digit_char(r[3:0]);
    s.b[5] = CH_SEMI;
    s.b[6] = digit_char(c[11:8]);
    s.b[7] = digit_char(c[7:4]);
    s.b[8] = digit_char(c[3:0]);
    s.b[9] = CH_H;
    s.m    = {1'b1, cm[0], cm[1], cm[2], 1'b1, rm[0], rm[1], rm[2], 2'b11};
    return s;
  endfunction

endpackage
`default_nettype wire

@@ rtl/tfde_ifs.sv @@
// Cell input and byte output channel interfaces
`default_nettype none
interface tfde_cell_if import tfde_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [GLYPH_W-1:0]        glyph_bytes;
  logic [LEN_W-1:0]          glyph_length;
  logic signed [COLOR_W-1:0] foreground;
  logic signed [COLOR_W-1:0] background;
  modport source(output valid, glyph_bytes, glyph_length, foreground, background,
                 input ready);
  modport sink(input valid, glyph_bytes, glyph_length, foreground, background,
               output ready);
endinterface

interface tfde_byte_if import tfde_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  modport source(output valid, out_byte, run_end, input ready);
  modport sink(input valid, out_byte, run_end, output ready);
endinterface
`default_nettype wire

@@ rtl/terminal_frame_diff_encoder.sv @@
// Terminal frame diff encoder: top level
//
// Cells of a frame enter on the cells channel in raster order, one per
// transaction. Each is compared with the previous frame's cell held in the
// frame store; a changed cell yields a run of ANSI bytes on the bytes
// channel (cursor move, colour changes, glyph), run_end on its last byte.
// Screen size comes in over the write port: index 0 columns, 1 rows.
// A changed cell is compared in the cell stage, then its run is loaded into
// the byte sequencer register that offers the first byte. Unchanged cells
// pass at one per cycle; a changed cell holds the cell stage until its run
// (1 to 36 bytes) has been loaded, so the byte rate of the output sets the
// pace for changed cells. The frame store is read and written once per
// cycle through its single port pair. Reset and every size write start a
// clearing pass over all MAX_COLUMNS*MAX_ROWS entries (8192 by default),
// during which no cell is taken. A stalled receiver holds the current byte;
// unchanged cells still pass and the next changed cell is taken and waits.
`default_nettype none
`include "terminal_frame_diff_encoder_defines.svh"
module terminal_frame_diff_encoder import tfde_pkg::*; #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  tfde_cell_if.sink        cells,
  tfde_byte_if.source      bytes
);
  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CPW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RPW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CEW    = $clog2(MAX_COLUMNS + 1);
  localparam int REW    = $clog2(MAX_ROWS + 1);
  localparam int CELL_W = $bits(cell_t);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic [LEN_W-1:0]   len;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [RPW-1:0]     row;
    logic [CPW-1:0]     col;
    logic [IW-1:0]      idx;
    logic [BCD_W-1:0]   row_bcd;
    logic [BCD_W-1:0]   col_bcd;
    logic               sof;
    logic               eol;
  } stage_t;

  logic [7:0]       screen_columns;
  logic [6:0]       screen_rows;
  logic [CEW-1:0]   cols_eff;
  logic [REW-1:0]   rows_eff;

  logic [RPW-1:0]   row_pos;
  logic [CPW-1:0]   col_pos;
  logic [IW-1:0]    idx_pos;
  logic [BCD_W-1:0] row_bcd;
  logic [BCD_W-1:0] col_bcd;
  logic             col_last;
  logic             row_last;

  logic             clr_active;
  logic [IW-1:0]    clr_addr;

  logic             a_valid;
  stage_t           a_q;
  stage_t           a_next;
  logic             a_fire;
  logic             in_acc;

  logic             ram_we;
  logic [IW-1:0]    waddr;
  logic [IW-1:0]    raddr;
  cell_t            wdata;
  logic [CELL_W-1:0] rdata;
  logic             fwd_hit;
  cell_t            fwd_data;
  cell_t            prev;
  logic [GLYPH_W-1:0] bmask;
  logic             changed;

  logic             cur_known;
  logic [RPW-1:0]   cur_row;
  logic [CPW-1:0]   cur_col;
  logic             fg_known;
  logic [COLOR_W-1:0] fg_sent;
  logic             bg_known;
  logic [COLOR_W-1:0] bg_sent;
  logic             eff_cur_known;
  logic             eff_fg_known;
  logic             eff_bg_known;
  logic             need_move;
  logic             send_fg;
  logic             send_bg;

  logic [SLOTS-1:0][7:0] tmpl;
  logic [SLOTS-1:0]      tmask;
  logic [SLOTS-1:0][7:0] gen_tmpl;
  logic [SLOTS-1:0]      gen_mask;
  logic [SLOTS-1:0]      gen_rest;
  logic [SLOTS-1:0]      gen_sel;
  logic                  gen_free;
  logic                  gen_load;
  logic                  out_acc;
  move_seg_t             mv;
  color_seg_t            fgs;
  color_seg_t            bgs;

  // size clamp
  always_comb begin
    if (screen_columns == 8'd0) cols_eff = CEW'(1);
    else if (32'(screen_columns) > MAX_COLUMNS) cols_eff = CEW'(MAX_COLUMNS);
    else cols_eff = CEW'(screen_columns);
    if (screen_rows == 7'd0) rows_eff = REW'(1);
    else if (32'(screen_rows) > MAX_ROWS) rows_eff = REW'(MAX_ROWS);
    else rows_eff = REW'(screen_rows);
  end

  assign col_last = ((CEW + 1)'(col_pos) + (CEW + 1)'(1)) >= (CEW + 1)'(cols_eff);
  assign row_last = ((REW + 1)'(row_pos) + (REW + 1)'(1)) >= (REW + 1)'(rows_eff);

  assign cells.ready = !clr_active && (!a_valid || a_fire);
  assign in_acc      = cells.valid && cells.ready;

  always_comb begin
    a_next.glyph   = cells.glyph_bytes;
    a_next.len     = (cells.glyph_length > LEN_MAX) ? LEN_MAX : cells.glyph_length;
    a_next.fg      = cells.foreground[8] ? COLOR_DEFAULT : cells.foreground;
    a_next.bg      = cells.background[8] ? COLOR_DEFAULT : cells.background;
    a_next.row     = row_pos;
    a_next.col     = col_pos;
    a_next.idx     = idx_pos;
    a_next.row_bcd = row_bcd;
    a_next.col_bcd = col_bcd;
    a_next.sof     = (row_pos == '0) && (col_pos == '0);
    a_next.eol     = col_last;
  end

  // config, raster position and clearing pass
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      row_pos    <= '0;
      col_pos    <= '0;
      idx_pos    <= '0;
      row_bcd    <= BCD_ONE;
      col_bcd    <= BCD_ONE;
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + IW'(1);
        if (clr_addr == LAST_IDX) clr_active <= 1'b0;
      end
      if (in_acc) begin
        if (col_last) begin
          col_pos <= '0;
          col_bcd <= BCD_ONE;
          if (row_last) begin
            row_pos <= '0;
            row_bcd <= BCD_ONE;
            idx_pos <= '0;
          end else begin
            row_pos <= row_pos + RPW'(1);
            row_bcd <= bcd_inc(row_bcd);
            idx_pos <= idx_pos + IW'(1);
          end
        end else begin
          col_pos <= col_pos + CPW'(1);
          col_bcd <= bcd_inc(col_bcd);
          idx_pos <= idx_pos + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns <= 8'd80;
      screen_rows    <= 7'd24;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COLUMNS: screen_columns <= cfg_data;
        REG_ROWS:    screen_rows    <= cfg_data[6:0];
        default:     ;
      endcase
    end
  end

  // cell stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_acc) begin
      a_valid <= 1'b1;
    end else if (a_fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) a_q <= a_next;
  end

  // frame store with same-cycle write forwarding
  assign raddr  = in_acc ? idx_pos : a_q.idx;
  assign ram_we = clr_active || (a_fire && changed);
  assign waddr  = clr_active ? clr_addr : a_q.idx;

  always_comb begin
    if (clr_active) begin
      wdata = '0;
    end else begin
      wdata.valid = 1'b1;
      wdata.bytes = a_q.glyph;
      wdata.len   = a_q.len;
      wdata.fg    = a_q.fg;
      wdata.bg    = a_q.bg;
    end
  end

  tfde_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) fwd_hit <= 1'b0;
    else     fwd_hit <= ram_we && (waddr == raddr);
  end

  always_ff @(posedge clk) begin
    fwd_data <= wdata;
  end

  assign prev = fwd_hit ? fwd_data : cell_t'(rdata);

  always_comb begin
    case (a_q.len)
      3'd0:    bmask = 32'h0000_0000;
      3'd1:    bmask = 32'h0000_00FF;
      3'd2:    bmask = 32'h0000_FFFF;
      3'd3:    bmask = 32'h00FF_FFFF;
      default: bmask = 32'hFFFF_FFFF;
    endcase
  end

  assign changed = !(prev.valid && (prev.len == a_q.len) && (prev.fg == a_q.fg) &&
                     (prev.bg == a_q.bg) && (((prev.bytes ^ a_q.glyph) & bmask) == '0));

  // cursor and colour tracking
  assign eff_cur_known = cur_known && !a_q.sof;
  assign eff_fg_known  = fg_known && !a_q.sof;
  assign eff_bg_known  = bg_known && !a_q.sof;
  assign need_move     = !eff_cur_known || (cur_row != a_q.row) || (cur_col != a_q.col);
  assign send_fg       = !eff_fg_known || (fg_sent != a_q.fg);
  assign send_bg       = !eff_bg_known || (bg_sent != a_q.bg);

  assign out_acc  = bytes.valid && bytes.ready;
  assign gen_rest = gen_mask & (gen_mask - SLOTS'(1));
  assign gen_sel  = gen_mask & (~gen_mask + SLOTS'(1));
  assign gen_free = (gen_mask == '0) || (out_acc && (gen_rest == '0));
  assign a_fire   = a_valid && (!changed || gen_free);
  assign gen_load = a_fire && changed;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_known <= 1'b0;
      fg_known  <= 1'b0;
      bg_known  <= 1'b0;
    end else if (a_fire) begin
      if (changed) begin
        cur_known <= !a_q.eol;
        fg_known  <= 1'b1;
        bg_known  <= 1'b1;
      end else begin
        cur_known <= eff_cur_known;
        fg_known  <= eff_fg_known;
        bg_known  <= eff_bg_known;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gen_load) begin
      cur_row <= a_q.eol ? '0 : a_q.row;
      cur_col <= a_q.eol ? '0 : a_q.col + CPW'(1);
      fg_sent <= a_q.fg;
      bg_sent <= a_q.bg;
    end
  end

  // byte run template
  assign mv  = move_seg(a_q.row_bcd, a_q.col_bcd);
  assign fgs = color_seg(a_q.fg, CH_FG);
  assign bgs = color_seg(a_q.bg, CH_BG);

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      tmpl[MV_BASE + i]  = mv.b[i];
      tmask[MV_BASE + i] = mv.m[i] && need_move;
    end
    for (int i = 0; i < 11; i++) begin
      tmpl[FG_BASE + i]  = fgs.b[i];
      tmask[FG_BASE + i] = fgs.m[i] && send_fg;
      tmpl[BG_BASE + i]  = bgs.b[i];
      tmask[BG_BASE + i] = bgs.m[i] && send_bg;
    end
    for (int i = 0; i < 4; i++) begin
      tmpl[GL_BASE + i]  = a_q.glyph[8*i +: 8];
      tmask[GL_BASE + i] = LEN_W'(i) < a_q.len;
    end
    if (a_q.len == '0) begin
      tmpl[GL_BASE]  = CH_SPACE;
      tmask[GL_BASE] = 1'b1;
    end
  end

  // byte sequencer: lowest set mask bit is the byte on offer
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_mask <= '0;
    end else if (gen_load) begin
      gen_mask <= tmask;
    end else if (out_acc) begin
      gen_mask <= gen_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_load) gen_tmpl <= tmpl;
  end

  always_comb begin
    bytes.out_byte = '0;
    for (int i = 0; i < SLOTS; i++) begin
      bytes.out_byte = bytes.out_byte | ({8{gen_sel[i]}} & gen_tmpl[i]);
    end
  end

  assign bytes.valid   = gen_mask != '0;
  assign bytes.run_end = gen_rest == '0;

  `TFDE_ASSERT_IMP(a_no_take_in_clear, clk, rst, clr_active, !cells.ready)
  `TFDE_ASSERT_NXT(a_changed_gives_bytes, clk, rst, a_fire && changed, bytes.valid)
  `TFDE_ASSERT_NXT(a_stage_holds, clk, rst, a_valid && !a_fire,
                   a_valid && $stable(a_q.idx))
  `TFDE_ASSERT_IMP(a_cursor_not_col0, clk, rst, cur_known, cur_col != '0)
endmodule
`default_nettype wire

@@ rtl/tfde_ram.sv @@
// Generic single write, single read RAM with registered read data
`default_nettype none
module tfde_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 8192,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for the terminal frame diff encoder: directed and random cells against a predictor
`default_nettype none
module tb;
  import tfde_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS_CAP = 128;
  localparam int ROWS_CAP = 64;
  localparam int DEPTH    = COLS_CAP * ROWS_CAP;
  localparam int NO_COLOR = -2;
  localparam int SETTLE   = 12;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } ansi_byte_t;

  typedef struct {
    logic [GLYPH_W-1:0] glyph;
    logic [LEN_W-1:0]   len;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    string              typed;
  } cell_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [0:0]       cfg_index = REG_COLUMNS;
  logic [CFG_W-1:0] cfg_data = '0;

  tfde_cell_if cells();
  tfde_byte_if bytes();

  terminal_frame_diff_encoder DUT (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cells(cells.sink), .bytes(bytes.source)
  );

  always #10 clk = ~clk;

  // predictor state
  bit                 seen_cell [DEPTH];
  logic [GLYPH_W-1:0] seen_glyph[DEPTH];
  int                 seen_len  [DEPTH];
  int                 seen_fg   [DEPTH];
  int                 seen_bg   [DEPTH];
  logic [7:0]         width_reg;
  logic [6:0]         height_reg;
  int                 raster_row, raster_col, cur_row, cur_col;
  bit                 cur_known;
  int                 fg_sent, bg_sent;

  ansi_byte_t ansi_q[$];
  int         errors = 0;
  int         send_idle = 0, recv_idle = 0;
  bit         squeeze = 1'b0;
  bit         holding = 1'b0;
  bit         held_once = 1'b0;

  function automatic void put_ch(logic [7:0] c);
    ansi_byte_t e;
    e.ch = c;
    e.last = 1'b0;
    ansi_q.push_back(e);
  endfunction

  function automatic void put_num(int v);
    if (v >= 100) put_ch(8'(8'h30 + (v / 100) % 10));
    if (v >= 10) put_ch(8'(8'h30 + (v / 10) % 10));
    put_ch(8'(8'h30 + v % 10));
  endfunction

  function automatic void put_sgr(int c, logic [7:0] lead);
    put_ch(CH_ESC);
    put_ch(CH_LBR);
    put_ch(lead);
    if (c < 0) begin
      put_ch(CH_NINE);
    end else begin
      put_ch(CH_EIGHT);
      put_ch(CH_SEMI);
      put_ch(CH_FIVE);
      put_ch(CH_SEMI);
      put_num(c);
    end
    put_ch(CH_M);
  endfunction

  function automatic void new_frame();
    raster_row = 0;
    raster_col = 0;
    cur_known = 1'b0;
    cur_row = 0;
    cur_col = 0;
    fg_sent = NO_COLOR;
    bg_sent = NO_COLOR;
  endfunction

  function automatic int eff_cols();
    return (width_reg == 0) ? 1 : (width_reg > COLS_CAP) ? COLS_CAP : int'(width_reg);
  endfunction

  function automatic int eff_rows();
    return (height_reg == 0) ? 1 : (height_reg > ROWS_CAP) ? ROWS_CAP : int'(height_reg);
  endfunction

  function automatic int norm_color(logic [COLOR_W-1:0] raw);
    return raw[8] ? -1 : int'(raw[7:0]);
  endfunction

  // raster index of the next cell, frame restart applied
  function automatic int next_index();
    if (raster_row >= eff_rows() || raster_col >= eff_cols()) return 0;
    return raster_row * eff_cols() + raster_col;
  endfunction

  function automatic void predict_cell(logic [GLYPH_W-1:0] g, logic [LEN_W-1:0] raw_len,
                                       logic [COLOR_W-1:0] raw_fg, logic [COLOR_W-1:0] raw_bg);
    int                 cols, rows, r, c, n, f, b, idx;
    logic [GLYPH_W-1:0] mask;
    cols = eff_cols();
    rows = eff_rows();
    if (raster_row >= rows || raster_col >= cols) new_frame();
    if (raster_row == 0 && raster_col == 0) new_frame();
    r = raster_row;
    c = raster_col;
    n = (raw_len > 4) ? 4 : int'(raw_len);
    f = norm_color(raw_fg);
    b = norm_color(raw_bg);
    idx = r * cols + c;
    if (idx >= DEPTH) idx = DEPTH - 1;
    mask = (n >= 4) ? '1 : ((32'h1 << (8 * n)) - 1);
    if (!(seen_cell[idx] && seen_len[idx] == n && seen_fg[idx] == f && seen_bg[idx] == b &&
          (seen_glyph[idx] & mask) == (g & mask))) begin
      if (!cur_known || cur_row != r || cur_col != c) begin
        put_ch(CH_ESC);
        put_ch(CH_LBR);
        put_num(r + 1);
        put_ch(CH_SEMI);
        put_num(c + 1);
        put_ch(CH_H);
      end
      if (f != fg_sent) begin
        put_sgr(f, CH_FG);
        fg_sent = f;
      end
      if (b != bg_sent) begin
        put_sgr(b, CH_BG);
        bg_sent = b;
      end
      if (n == 0) put_ch(CH_SPACE);
      for (int i = 0; i < n; i++) put_ch(g[8*i +: 8]);
      ansi_q[$].last = 1'b1;
      cur_known = (c + 1 < cols);
      cur_row = cur_known ? r : 0;
      cur_col = cur_known ? c + 1 : 0;
      seen_cell[idx] = 1'b1;
      seen_glyph[idx] = g;
      seen_len[idx] = n;
      seen_fg[idx] = f;
      seen_bg[idx] = b;
    end
    if (c + 1 >= cols) begin
      raster_col = 0;
      raster_row = (r + 1 >= rows) ? 0 : r + 1;
    end else begin
      raster_col = c + 1;
    end
  endfunction

  function automatic void clear_seen();
    for (int i = 0; i < DEPTH; i++) seen_cell[i] = 1'b0;
    new_frame();
  endfunction

  task automatic wait_drained();
    while (ansi_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(logic [0:0] which, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (which == REG_COLUMNS) width_reg = value;
    else height_reg = value[6:0];
    clear_seen();
  endtask

  task automatic send_cell(cell_row_t row);
    int gap;
    int mark;
    gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      cells.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cells.valid <= 1'b1;
    cells.glyph_bytes <= row.glyph;
    cells.glyph_length <= row.len;
    cells.foreground <= row.fg;
    cells.background <= row.bg;
    do @(posedge clk); while (!cells.ready);
    mark = ansi_q.size();
    predict_cell(row.glyph, row.len, row.fg, row.bg);
    if (row.typed.len() != 0) begin
      while (ansi_q.size() > mark) ansi_q.delete(ansi_q.size() - 1);
      for (int i = 0; i < row.typed.len(); i++) put_ch(row.typed[i]);
      ansi_q[$].last = 1'b1;
    end
  endtask

  function automatic logic [COLOR_W-1:0] rand_color();
    case ($urandom_range(3))
      0: return COLOR_DEFAULT;
      1: return {1'b1, 8'($urandom)};
      2: return 9'($urandom_range(0, 3));
      default: return {1'b0, 8'($urandom)};
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] rand_neg();
    return {1'b1, 8'($urandom)};
  endfunction

  // mostly repaint the stored cell, possibly with junk in unused bytes
  task automatic send_random(int count);
    cell_row_t row;
    int        idx;
    for (int k = 0; k < count; k++) begin
      idx = next_index();
      row.typed = "";
      if (seen_cell[idx] && $urandom_range(99) < 60) begin
        row.len = 3'(seen_len[idx]);
        if (seen_len[idx] == 4 && $urandom_range(1)) row.len = 3'($urandom_range(5, 7));
        row.glyph = seen_glyph[idx];
        for (int i = seen_len[idx]; i < 4; i++)
          if ($urandom_range(1)) row.glyph[8*i +: 8] = 8'($urandom);
        row.fg = (seen_fg[idx] < 0) ? rand_neg() : 9'(seen_fg[idx]);
        row.bg = (seen_bg[idx] < 0) ? rand_neg() : 9'(seen_bg[idx]);
        if ($urandom_range(99) < 15) row.fg = rand_color();
      end else begin
        row.glyph = $urandom;
        row.len = 3'($urandom_range(0, 7));
        row.fg = rand_color();
        row.bg = rand_color();
      end
      send_cell(row);
    end
    cells.valid <= 1'b0;
  endtask

  task automatic set_idling(int s, int r);
    send_idle = s;
    recv_idle = r;
  endtask

  cell_row_t directed[$] = '{
    '{32'h0000_0000, 3'd0, COLOR_DEFAULT, COLOR_DEFAULT, "\033[1;1H\033[39m\033[49m "},
    '{32'h0000_0041, 3'd1, 9'd255, 9'd0, "\033[38;5;255m\033[48;5;0mA"},
    '{32'hFFFF_FFFF, 3'd4, 9'd0, 9'd255, ""},
    '{32'h8DA0_9FF0, 3'd7, COLOR_DEFAULT, 9'h100, ""},
    '{32'h00BC_A9E2, 3'd3, 9'd9, 9'd99, ""},
    '{32'h0000_A9C3, 3'd2, 9'd100, 9'd10, ""},
    '{32'hAAAA_AA42, 3'd1, 9'd100, 9'd10, "B"},
    '{32'h1234_5678, 3'd5, 9'h1AB, 9'd1, ""},
    '{32'h0000_0000, 3'd6, 9'd200, COLOR_DEFAULT, ""},
    '{32'hFFFF_FF20, 3'd0, 9'd200, COLOR_DEFAULT, " "},
    '{32'h7F7F_7F7F, 3'd4, 9'h17F, 9'd128, ""},
    '{32'h8080_8080, 3'd3, 9'd127, 9'h180, ""},
    '{32'h0000_0031, 3'd1, 9'd0, 9'd0, ""},
    '{32'h0000_0000, 3'd0, 9'd255, 9'd255, ""},
    '{32'h0000_007E, 3'd1, COLOR_DEFAULT, COLOR_DEFAULT, ""},
    '{32'h5555_5555, 3'd2, 9'd55, 9'd5, ""}
  };

  // one long receiver hold while cells keep coming
  int hold_left = 0;
  always @(posedge clk) begin
    if (squeeze && !holding && !held_once) begin
      hold_left <= 400;
      holding <= 1'b1;
      held_once <= 1'b1;
    end else if (holding) begin
      if (hold_left == 1) holding <= 1'b0;
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    ansi_byte_t e;
    if (rst) begin
      bytes.ready <= 1'b0;
    end else begin
      if (bytes.valid && bytes.ready) begin
        if (ansi_q.size() == 0) begin
          $display("%0t: unexpected byte %h run_end %b", $time, bytes.out_byte, bytes.run_end);
          errors++;
        end else begin
          e = ansi_q.pop_front();
          if (bytes.out_byte !== e.ch || bytes.run_end !== e.last) begin
            $display("%0t: expected byte %h run_end %b, got %h run_end %b", $time,
                     e.ch, e.last, bytes.out_byte, bytes.run_end);
            errors++;
          end
        end
      end
      bytes.ready <= !holding && ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    cells.valid = 1'b0;
    cells.glyph_bytes = '0;
    cells.glyph_length = '0;
    cells.foreground = '0;
    cells.background = '0;
    bytes.ready = 1'b0;
    width_reg = 8'd80;
    height_reg = 7'd24;
    clear_seen();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_cell(directed[i]);
    cells.valid <= 1'b0;
    wait_drained();

    write_size(REG_COLUMNS, 8'd4);
    write_size(REG_ROWS, 8'd3);
    send_random(30);
    set_idling(80, 0);
    send_random(30);
    set_idling(0, 80);
    squeeze = 1'b1;
    send_random(30);
    squeeze = 1'b0;
    set_idling(22, 22);
    send_random(30);
    wait_drained();

    set_idling(0, 0);
    write_size(REG_COLUMNS, 8'd0);
    write_size(REG_ROWS, 8'd0);
    send_random(12);
    wait_drained();
    write_size(REG_COLUMNS, 8'd255);
    write_size(REG_ROWS, 8'd127);
    set_idling(22, 22);
    send_random(12);
    wait_drained();
    write_size(REG_COLUMNS, 8'd1);
    write_size(REG_ROWS, 8'd64);
    send_random(12);
    wait_drained();
    write_size(REG_COLUMNS, 8'd128);
    write_size(REG_ROWS, 8'd1);
    send_random(12);
    wait_drained();
    write_size(REG_COLUMNS, 8'd3);
    write_size(REG_ROWS, 8'd2);
    set_idling(0, 0);
    send_random(8);
    wait_drained();

    if (errors == 0 && ansi_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/tfde_pkg.sv
rtl/tfde_ifs.sv
rtl/tfde_ram.sv
rtl/terminal_frame_diff_encoder.sv
verif/tb.sv
